>>> hdl/bis_pkg.sv
// Shared types, sizes and step codes for the bilinear image sampler.
// Depends on nothing; the sampler top level refers to it by scoped names.
package bis_pkg;

  // Image store geometry and number formats.
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int FRAC_BITS   = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int COORD_W     = 16;
  localparam int INT_W       = COORD_W - FRAC_BITS;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int ADDR_W      = COL_W + ROW_W;
  localparam int DEPTH       = MAX_WIDTH * MAX_HEIGHT;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int WEIGHT_W    = FRAC_BITS + 1;
  localparam int LINE_W      = SAMPLE_BITS + FRAC_BITS;
  localparam int PROD_W      = LINE_W + WEIGHT_W;
  localparam int SUM_W       = SAMPLE_BITS + 2 * FRAC_BITS;
  localparam int OUT_W       = 24;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // Input actions.
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Steps of the read and multiply-accumulate sequence.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_RD_A  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_TOP0  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_TOP1  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_BOT0  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_BOT1  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_SUM0  = 3'd5;
  localparam logic [STEP_W-1:0] STEP_SUM1  = 3'd6;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // Last usable index for a size register: zero acts as one, and a size
  // above the store acts as the store size.
  function automatic logic [CFG_W-1:0] last_index(input logic [CFG_W-1:0] size,
                                                  input logic [CFG_W-1:0] limit);
    logic [CFG_W-1:0] res;
    if (size == '0) begin
      res = '0;
    end else if (size > limit) begin
      res = limit - CFG_W'(1);
    end else begin
      res = size - CFG_W'(1);
    end
    return res;
  endfunction

endpackage

>>> hdl/bilinear_image_sampler_unit.sv
// Bilinear image sampler: a 256 x 256 store of 16-bit pixels with edge clamping.
// A pixel write is taken while idle. A sample runs from acceptance to the output word as
// one store read, then six multiply-accumulate steps on a shared 24 x 9 multiplier that
// overlap the other three reads, then a hand-off state that loads the output register.
// No new word is taken until the hand-off, which waits while the output word is held off;
// the input stalls meanwhile. Synchronous reset sets the sizes to 256; store undefined.
module bilinear_image_sampler_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_write_en,
  input  logic [bis_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bis_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_action,
  input  logic [7:0]                       in_write_column,
  input  logic [7:0]                       in_write_row,
  input  logic [15:0]                      in_pixel_value,
  input  logic [bis_pkg::COORD_W-1:0]      in_sample_x,
  input  logic [bis_pkg::COORD_W-1:0]      in_sample_y,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bis_pkg::OUT_W-1:0]        out_sample_value,
  output logic                             out_out_of_range
);

  bis_pkg::state_t                  state_r, state_nxt;
  logic [bis_pkg::STEP_W-1:0]       step_r, step_nxt;
  logic [bis_pkg::CFG_W-1:0]        width_r, width_nxt;
  logic [bis_pkg::CFG_W-1:0]        height_r, height_nxt;
  logic [bis_pkg::COL_W-1:0]        ix_r, ix_nxt, ix1_r, ix1_nxt;
  logic [bis_pkg::ROW_W-1:0]        iy_r, iy_nxt, iy1_r, iy1_nxt;
  logic [bis_pkg::FRAC_BITS-1:0]    tx_r, tx_nxt, ty_r, ty_nxt;
  logic                             oor_r, oor_nxt;
  logic [bis_pkg::LINE_W-1:0]       top_r, top_nxt, bot_r, bot_nxt;
  logic [bis_pkg::SUM_W-1:0]        sum_r, sum_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [bis_pkg::OUT_W-1:0]        out_value_r, out_value_nxt;
  logic                             out_oor_r, out_oor_nxt;

  logic [bis_pkg::SAMPLE_BITS-1:0]  store [bis_pkg::DEPTH];
  logic [bis_pkg::SAMPLE_BITS-1:0]  rd_data_r;
  logic [bis_pkg::ADDR_W-1:0]       mem_addr;
  logic                             mem_we;

  logic [bis_pkg::CFG_W-1:0]        last_col, last_row;
  logic [bis_pkg::CFG_W-1:0]        req_ix, req_iy;
  logic                             in_take;
  logic                             out_free;
  logic [bis_pkg::LINE_W-1:0]       mul_a;
  logic [bis_pkg::WEIGHT_W-1:0]     mul_b;
  logic [bis_pkg::PROD_W-1:0]       prod;
  logic [bis_pkg::WEIGHT_W-1:0]     wx0, wx1, wy0, wy1;

  // Effective last column and row of the image in use.
  assign last_col = bis_pkg::last_index(width_r, bis_pkg::CFG_W'(bis_pkg::MAX_WIDTH));
  assign last_row = bis_pkg::last_index(height_r, bis_pkg::CFG_W'(bis_pkg::MAX_HEIGHT));

  // Integer parts of the requested coordinates, widened for comparison.
  assign req_ix = bis_pkg::CFG_W'(in_sample_x[bis_pkg::COORD_W-1:bis_pkg::FRAC_BITS]);
  assign req_iy = bis_pkg::CFG_W'(in_sample_y[bis_pkg::COORD_W-1:bis_pkg::FRAC_BITS]);

  // Handshake: input is taken only while idle; the output register frees up
  // when it is empty or its word is being taken.
  assign in_stall = (state_r != bis_pkg::ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Bilinear weights.
  assign wx1 = bis_pkg::WEIGHT_W'(tx_r);
  assign wy1 = bis_pkg::WEIGHT_W'(ty_r);
  assign wx0 = bis_pkg::WEIGHT_W'(1 << bis_pkg::FRAC_BITS) - wx1;
  assign wy0 = bis_pkg::WEIGHT_W'(1 << bis_pkg::FRAC_BITS) - wy1;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = bis_pkg::LINE_W'(rd_data_r);
    mul_b = wx0;
    case (step_r)
      bis_pkg::STEP_TOP1, bis_pkg::STEP_BOT1: begin
        mul_b = wx1;
      end
      bis_pkg::STEP_SUM0: begin
        mul_a = top_r;
        mul_b = wy0;
      end
      bis_pkg::STEP_SUM1: begin
        mul_a = bot_r;
        mul_b = wy1;
      end
      default: begin
        mul_b = wx0;
      end
    endcase
  end

  assign prod = bis_pkg::PROD_W'(mul_a) * bis_pkg::PROD_W'(mul_b);

  // Store address: the write address while idle, else the neighbor to fetch.
  always_comb begin
    mem_we   = 1'b0;
    mem_addr = {in_write_row, in_write_column};
    if (state_r == bis_pkg::ST_IDLE) begin
      mem_we = in_take && (in_action == bis_pkg::ACT_WRITE);
    end else begin
      case (step_r)
        bis_pkg::STEP_RD_A: mem_addr = {iy_r, ix_r};
        bis_pkg::STEP_TOP0: mem_addr = {iy_r, ix1_r};
        bis_pkg::STEP_TOP1: mem_addr = {iy1_r, ix_r};
        bis_pkg::STEP_BOT0: mem_addr = {iy1_r, ix1_r};
        default:            mem_addr = {iy_r, ix_r};
      endcase
    end
  end

  // Image store: single port, registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_addr] <= in_pixel_value;
    end
    rd_data_r <= store[mem_addr];
  end

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    ix_nxt        = ix_r;
    ix1_nxt       = ix1_r;
    iy_nxt        = iy_r;
    iy1_nxt       = iy1_r;
    tx_nxt        = tx_r;
    ty_nxt        = ty_r;
    oor_nxt       = oor_r;
    top_nxt       = top_r;
    bot_nxt       = bot_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_oor_nxt   = out_oor_r;

    // Configuration writes; unknown indexes are dropped.
    if (cfg_write_en) begin
      if (cfg_index == bis_pkg::REG_IMAGE_WIDTH) begin
        width_nxt = cfg_data;
      end else if (cfg_index == bis_pkg::REG_IMAGE_HEIGHT) begin
        height_nxt = cfg_data;
      end
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      bis_pkg::ST_IDLE: begin
        // Latch clamped coordinates of a sample request.
        if (in_take && (in_action == bis_pkg::ACT_SAMPLE)) begin
          oor_nxt = 1'b0;
          if (req_ix > last_col) begin
            ix_nxt  = bis_pkg::COL_W'(last_col);
            oor_nxt = 1'b1;
          end else begin
            ix_nxt = bis_pkg::COL_W'(req_ix);
          end
          if (req_iy > last_row) begin
            iy_nxt  = bis_pkg::ROW_W'(last_row);
            oor_nxt = 1'b1;
          end else begin
            iy_nxt = bis_pkg::ROW_W'(req_iy);
          end
          ix1_nxt   = (bis_pkg::CFG_W'(ix_nxt) == last_col) ? ix_nxt
                                                            : ix_nxt + bis_pkg::COL_W'(1);
          iy1_nxt   = (bis_pkg::CFG_W'(iy_nxt) == last_row) ? iy_nxt
                                                            : iy_nxt + bis_pkg::ROW_W'(1);
          tx_nxt    = in_sample_x[bis_pkg::FRAC_BITS-1:0];
          ty_nxt    = in_sample_y[bis_pkg::FRAC_BITS-1:0];
          step_nxt  = bis_pkg::STEP_RD_A;
          state_nxt = bis_pkg::ST_CALC;
        end
      end
      bis_pkg::ST_CALC: begin
        // One multiply-accumulate per step after the first read, on the shared multiplier.
        step_nxt = step_r + bis_pkg::STEP_W'(1);
        case (step_r)
          bis_pkg::STEP_TOP0: top_nxt = bis_pkg::LINE_W'(prod);
          bis_pkg::STEP_TOP1: top_nxt = top_r + bis_pkg::LINE_W'(prod);
          bis_pkg::STEP_BOT0: bot_nxt = bis_pkg::LINE_W'(prod);
          bis_pkg::STEP_BOT1: bot_nxt = bot_r + bis_pkg::LINE_W'(prod);
          bis_pkg::STEP_SUM0: sum_nxt = bis_pkg::SUM_W'(prod);
          bis_pkg::STEP_SUM1: begin
            sum_nxt   = sum_r + bis_pkg::SUM_W'(prod);
            state_nxt = bis_pkg::ST_DONE;
          end
          default: begin
            top_nxt = top_r;
          end
        endcase
      end
      bis_pkg::ST_DONE: begin
        // Hand the truncated sum to the output register once it is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = bis_pkg::OUT_W'(sum_r >> bis_pkg::FRAC_BITS);
          out_oor_nxt   = oor_r;
          state_nxt     = bis_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bis_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bis_pkg::ST_IDLE;
      step_r      <= bis_pkg::STEP_RD_A;
      width_r     <= bis_pkg::CFG_W'(bis_pkg::MAX_WIDTH);
      height_r    <= bis_pkg::CFG_W'(bis_pkg::MAX_HEIGHT);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ix_r        <= ix_nxt;
    ix1_r       <= ix1_nxt;
    iy_r        <= iy_nxt;
    iy1_r       <= iy1_nxt;
    tx_r        <= tx_nxt;
    ty_r        <= ty_nxt;
    oor_r       <= oor_nxt;
    top_r       <= top_nxt;
    bot_r       <= bot_nxt;
    sum_r       <= sum_nxt;
    out_value_r <= out_value_nxt;
    out_oor_r   <= out_oor_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;
  assign out_out_of_range = out_oor_r;

  // A new output word appears only from the hand-off state.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == bis_pkg::ST_DONE))
    else $error("output word loaded outside the hand-off state");

  // An accepted sample request starts the sequence at its first step.
  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_action == bis_pkg::ACT_SAMPLE)
    |=> (state_r == bis_pkg::ST_CALC && step_r == bis_pkg::STEP_RD_A))
    else $error("sample request did not start the sequence");

  // The step counter never runs past the last accumulate step.
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bis_pkg::ST_CALC) |-> (step_r <= bis_pkg::STEP_SUM1))
    else $error("step counter out of range");

  // Leaving the hand-off state always loads the output register.
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bis_pkg::ST_DONE && out_free) |=> out_valid_r)
    else $error("hand-off finished without an output word");

endmodule

>>> bench/tb_bilinear_image_sampler_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for bilinear_image_sampler_unit: a queue-fed driver, a monitor that
// predicts every sample from its own image copy, and a watchdog. Depends on bis_pkg and the sampler unit.
module tb_bilinear_image_sampler_unit;

  localparam int ITEM_TARGET  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 3000;

  // Register indexes with no register behind them.
  localparam logic [bis_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = bis_pkg::CFG_IDX_W'(2);
  localparam logic [bis_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = bis_pkg::CFG_IDX_W'(3);

  typedef struct packed {
    logic        action;
    logic [7:0]  column;
    logic [7:0]  row;
    logic [15:0] pixel;
    logic [15:0] x;
    logic [15:0] y;
  } sampler_word_t;

  typedef struct packed {
    logic [bis_pkg::OUT_W-1:0] value;
    logic                      oor;
  } sample_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_write_en = 1'b0;
  logic [bis_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bis_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_action = 1'b0;
  logic [7:0]                    in_write_column = '0;
  logic [7:0]                    in_write_row = '0;
  logic [15:0]                   in_pixel_value = '0;
  logic [bis_pkg::COORD_W-1:0]   in_sample_x = '0;
  logic [bis_pkg::COORD_W-1:0]   in_sample_y = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [bis_pkg::OUT_W-1:0]     out_sample_value;
  logic                          out_out_of_range;

  // Predictor state: its own image copy and size registers.
  logic [bis_pkg::SAMPLE_BITS-1:0] img_model [bis_pkg::DEPTH];
  logic [bis_pkg::CFG_W-1:0]       model_width = bis_pkg::CFG_W'(256);
  logic [bis_pkg::CFG_W-1:0]       model_height = bis_pkg::CFG_W'(256);

  // Stimulus bookkeeping: pixels that a queued write has defined.
  bit                     pix_known [bis_pkg::DEPTH];
  sampler_word_t          pending_words[$];
  sample_result_t         expected_samples[$];
  int unsigned            items_queued = 0;
  int unsigned            accepted_count = 0;
  int unsigned            mismatch_count = 0;
  bit                     in_took = 1'b0;
  bit                     send_gaps_on = 1'b1;
  bit                     recv_stalls_on = 1'b1;
  int unsigned            gap_left = 0;
  int unsigned            stall_left = 0;
  int unsigned            hold_left = 0;
  int unsigned            hold_requests = 0;
  int unsigned            hold_served = 0;
  int unsigned            stuck_cycles = 0;

  bilinear_image_sampler_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_write_column  (in_write_column),
    .in_write_row     (in_write_row),
    .in_pixel_value   (in_pixel_value),
    .in_sample_x      (in_sample_x),
    .in_sample_y      (in_sample_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_value (out_sample_value),
    .out_out_of_range (out_out_of_range)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Size register as the block uses it: zero acts as one, large values as the store size.
  function automatic int unsigned span_of(input logic [bis_pkg::CFG_W-1:0] v,
                                          input int unsigned lim);
    int unsigned s;
    s = v;
    if (s < 1) s = 1;
    if (s > lim) s = lim;
    return s;
  endfunction

  // Integer cells of the four neighbors, saturated and clamped to the sizes in use.
  function automatic void locate_cells(input logic [15:0] x, input logic [15:0] y,
                                       output int unsigned c0, output int unsigned c1,
                                       output int unsigned r0, output int unsigned r1,
                                       output logic sat);
    int unsigned w, h;
    w = span_of(model_width, bis_pkg::MAX_WIDTH);
    h = span_of(model_height, bis_pkg::MAX_HEIGHT);
    c0 = x >> bis_pkg::FRAC_BITS;
    r0 = y >> bis_pkg::FRAC_BITS;
    sat = 1'b0;
    if (c0 > w - 1) begin
      c0 = w - 1;
      sat = 1'b1;
    end
    if (r0 > h - 1) begin
      r0 = h - 1;
      sat = 1'b1;
    end
    c1 = (c0 + 1 > w - 1) ? w - 1 : c0 + 1;
    r1 = (r0 + 1 > h - 1) ? h - 1 : r0 + 1;
  endfunction

  // Exact bilinear blend with 2*FRAC_BITS fraction bits, then truncated to FRAC_BITS.
  function automatic sample_result_t blend_sample(input logic [15:0] x, input logic [15:0] y);
    int unsigned    c0, c1, r0, r1;
    logic           sat;
    logic [63:0]    one, tx, ty, a, b, c, d, top, bot, acc;
    sample_result_t res;
    locate_cells(x, y, c0, c1, r0, r1, sat);
    one = 64'(1) << bis_pkg::FRAC_BITS;
    tx  = 64'(x) & (one - 1);
    ty  = 64'(y) & (one - 1);
    a   = 64'(img_model[r0 * bis_pkg::MAX_WIDTH + c0]);
    b   = 64'(img_model[r0 * bis_pkg::MAX_WIDTH + c1]);
    c   = 64'(img_model[r1 * bis_pkg::MAX_WIDTH + c0]);
    d   = 64'(img_model[r1 * bis_pkg::MAX_WIDTH + c1]);
    top = a * (one - tx) + b * tx;
    bot = c * (one - tx) + d * tx;
    acc = top * (one - ty) + bot * ty;
    res.value = bis_pkg::OUT_W'(acc >> bis_pkg::FRAC_BITS);
    res.oor   = sat;
    return res;
  endfunction

  function automatic void note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", what);
  endfunction

  // Gap length for either side: mostly short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [15:0] rand_pixel();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Coordinate mostly inside the image in use, sometimes at its edge or far beyond it.
  function automatic logic [15:0] rand_coord(input int unsigned span);
    int unsigned r, top;
    logic [15:0] pick;
    top = span * 256 - 1;
    r = $urandom_range(0, 99);
    if (r < 50) pick = 16'($urandom_range(0, top));
    else if (r < 62) pick = 16'($urandom_range(0, span - 1) << bis_pkg::FRAC_BITS);
    else if (r < 72) pick = 16'(((span - 1) << bis_pkg::FRAC_BITS) | $urandom_range(0, 255));
    else if (r < 87) pick = 16'($urandom);
    else begin
      case ($urandom_range(0, 3))
        0: pick = 16'h0000;
        1: pick = 16'hFFFF;
        2: pick = 16'(span << bis_pkg::FRAC_BITS);
        default: pick = 16'(top);
      endcase
    end
    return pick;
  endfunction

  function automatic logic [bis_pkg::CFG_W-1:0] pick_size();
    int unsigned r;
    int unsigned edges [7] = '{0, 1, 2, 255, 256, 257, 511};
    r = $urandom_range(0, 99);
    if (r < 50) return bis_pkg::CFG_W'($urandom_range(1, 16));
    if (r < 75) return bis_pkg::CFG_W'($urandom_range(0, 511));
    return bis_pkg::CFG_W'(edges[$urandom_range(0, 6)]);
  endfunction

  task automatic queue_write(input logic [7:0] col, input logic [7:0] row,
                             input logic [15:0] val);
    sampler_word_t w;
    w.action = bis_pkg::ACT_WRITE;
    w.column = col;
    w.row    = row;
    w.pixel  = val;
    w.x      = 16'($urandom);
    w.y      = 16'($urandom);
    pending_words = {pending_words, w};
    pix_known[row * bis_pkg::MAX_WIDTH + col] = 1'b1;
    items_queued++;
  endtask

  // A sample never reads an undefined pixel: missing neighbors get written first.
  task automatic queue_sample(input logic [15:0] x, input logic [15:0] y);
    int unsigned   cols [2], rows [2];
    logic          sat;
    sampler_word_t w;
    locate_cells(x, y, cols[0], cols[1], rows[0], rows[1], sat);
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        if (!pix_known[rows[i] * bis_pkg::MAX_WIDTH + cols[j]])
          queue_write(8'(cols[j]), 8'(rows[i]), rand_pixel());
      end
    end
    w.action = bis_pkg::ACT_SAMPLE;
    w.column = 8'($urandom);
    w.row    = 8'($urandom);
    w.pixel  = 16'($urandom);
    w.x      = x;
    w.y      = y;
    pending_words = {pending_words, w};
    items_queued++;
  endtask

  // Wait until every word is taken and every sample returned, then let the block settle.
  task automatic wait_idle();
    while (accepted_count != items_queued || expected_samples.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bis_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bis_pkg::CFG_W-1:0] val);
    cfg_write_en = 1'b1;
    cfg_index    = idx;
    cfg_data     = val;
    @(negedge clk);
    cfg_write_en = 1'b0;
    if (idx == bis_pkg::REG_IMAGE_WIDTH) model_width = val;
    else if (idx == bis_pkg::REG_IMAGE_HEIGHT) model_height = val;
  endtask

  task automatic apply_setting(input logic [bis_pkg::CFG_W-1:0] w,
                               input logic [bis_pkg::CFG_W-1:0] h);
    wait_idle();
    write_reg(bis_pkg::REG_IMAGE_WIDTH, w);
    write_reg(bis_pkg::REG_IMAGE_HEIGHT, h);
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, bis_pkg::CFG_W'($urandom));
  endtask

  task automatic random_burst(input int unsigned n);
    int unsigned target, w, h;
    target = items_queued + n;
    w = span_of(model_width, bis_pkg::MAX_WIDTH);
    h = span_of(model_height, bis_pkg::MAX_HEIGHT);
    while (items_queued < target) begin
      if ($urandom_range(0, 99) < 30) begin
        if ($urandom_range(0, 1))
          queue_write(8'($urandom_range(0, w - 1)), 8'($urandom_range(0, h - 1)), rand_pixel());
        else
          queue_write(8'($urandom), 8'($urandom), rand_pixel());
      end else begin
        queue_sample(rand_coord(w), rand_coord(h));
      end
    end
  endtask

  // Driver: offers the next word at the falling edge and holds it while stalled.
  always @(negedge clk) begin
    sampler_word_t cur;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // Stalled: the word stays as it is.
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (pending_words.size() != 0) begin
      cur = pending_words.pop_front();
      in_action       <= cur.action;
      in_write_column <= cur.column;
      in_write_row    <= cur.row;
      in_pixel_value  <= cur.pixel;
      in_sample_x     <= cur.x;
      in_sample_y     <= cur.y;
      in_valid        <= 1'b1;
      if (send_gaps_on) gap_left = pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, and a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (recv_stalls_on) stall_left = pick_gap();
    end
  end

  // Monitor: checks each returned word, then predicts from each accepted input word.
  always @(posedge clk) begin
    sample_result_t want;
    if (!rst_n) begin
      in_took = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          note_mismatch($sformatf("unexpected result word: value %h range %b",
                                  out_sample_value, out_out_of_range));
        end else begin
          want = expected_samples.pop_front();
          if (out_sample_value !== want.value || out_out_of_range !== want.oor)
            note_mismatch($sformatf("sample mismatch: expected value %h range %b, got %h %b",
                                    want.value, want.oor, out_sample_value, out_out_of_range));
        end
      end
      in_took = in_valid && !in_stall;
      if (in_took) begin
        accepted_count++;
        if (in_action == bis_pkg::ACT_WRITE)
          img_model[{in_write_row, in_write_column}] = in_pixel_value;
        else
          expected_samples = {expected_samples, blend_sample(in_sample_x, in_sample_y)};
      end
    end
  end

  // Watchdog: too long without any word moving on either side ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned preset_w [8];
    int unsigned preset_h [8];

    preset_w = '{1, 2, 256, 1, 256, 511, 0, 3};
    preset_h = '{1, 2, 256, 256, 1, 0, 511, 5};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Full-size image: exact pixel, midpoint, largest fraction, last column and row.
    queue_write(8'd0, 8'd0, 16'h0000);
    queue_write(8'd1, 8'd0, 16'hFFFF);
    queue_write(8'd0, 8'd1, 16'hFFFF);
    queue_write(8'd1, 8'd1, 16'h8001);
    queue_sample(16'h0000, 16'h0000);
    queue_sample(16'h0080, 16'h0080);
    queue_sample(16'h00FF, 16'h00FF);
    queue_write(8'd255, 8'd255, 16'hFFFF);
    queue_write(8'd254, 8'd255, 16'hFFFF);
    queue_write(8'd255, 8'd254, 16'hFFFF);
    queue_write(8'd254, 8'd254, 16'hFFFF);
    queue_sample(16'hFFFF, 16'hFFFF);
    queue_sample(16'hFEFF, 16'hFE01);

    // Small image: saturation on x and on y, edge clamp, a write beyond the size,
    // and writes to indexes with no register.
    wait_idle();
    write_reg(bis_pkg::REG_IMAGE_WIDTH, bis_pkg::CFG_W'(4));
    write_reg(bis_pkg::REG_IMAGE_HEIGHT, bis_pkg::CFG_W'(3));
    write_reg(REG_SPARE_2, bis_pkg::CFG_W'(9'h1FF));
    write_reg(REG_SPARE_3, bis_pkg::CFG_W'(9'h155));
    queue_sample(16'h0580, 16'h0140);
    queue_sample(16'h0140, 16'hFF80);
    queue_sample(16'h03C0, 16'h0240);
    queue_write(8'd200, 8'd100, 16'hBEEF);

    // Zero sizes act as one; oversized ones act as the store size.
    apply_setting(bis_pkg::CFG_W'(0), bis_pkg::CFG_W'(0));
    queue_sample(16'h1234, 16'h5678);
    apply_setting(bis_pkg::CFG_W'(511), bis_pkg::CFG_W'(300));
    queue_sample(16'hC8FF, 16'h6401);

    // Random phases, each under its own size setting and idling pattern.
    phase = 0;
    while (items_queued < ITEM_TARGET) begin
      if (phase < 8)
        apply_setting(bis_pkg::CFG_W'(preset_w[phase]), bis_pkg::CFG_W'(preset_h[phase]));
      else
        apply_setting(pick_size(), pick_size());
      send_gaps_on   = ($urandom_range(0, 3) != 0);
      recv_stalls_on = ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        // The receiver holds off while the sender keeps offering words.
        send_gaps_on = 1'b0;
        hold_requests++;
      end
      random_burst($urandom_range(80, 200));
      phase++;
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/bis_pkg.sv
hdl/bilinear_image_sampler_unit.sv
bench/tb_bilinear_image_sampler_unit.sv
